### rtl/rau_pkg.sv
package rau_pkg;

  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_ZERO = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [1:0] status;
    logic       a_greater;
    logic       a_equal;
    logic       a_less;
    logic       neg;
  } rau_ctl_t;

endpackage

### rtl/rau_if.sv
interface rau_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic signed [W-1:0] a_numerator;
  logic signed [W-1:0] a_denominator;
  logic signed [W-1:0] b_numerator;
  logic signed [W-1:0] b_denominator;

  modport source (output valid, operation, a_numerator, a_denominator,
                  b_numerator, b_denominator, input ready);
  modport sink (input valid, operation, a_numerator, a_denominator,
                b_numerator, b_denominator, output ready);
endinterface

interface rau_out_if import rau_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] result_numerator;
  logic [DEN_W-1:0]        result_denominator;
  logic [1:0]              status;
  logic                    a_greater;
  logic                    a_equal;
  logic                    a_less;

  modport source (output valid, result_numerator, result_denominator, status,
                  a_greater, a_equal, a_less, input ready);
  modport sink (input valid, result_numerator, result_denominator, status,
                a_greater, a_equal, a_less, output ready);
endinterface

### rtl/rational_arith_unit_core.sv
// The front forms four products on one shared multiplier in its F_MUL state, then
// offers the word in F_PUSH; the word passes through a two-deep queue into the back,
// which runs binary gcd (B_GCD), restoring division of both magnitudes (B_DIV) and
// presents the result in B_OUT.
// Throughput: one word per back-end run; a two-deep queue lets the front take
// the next word while the back works. Error words skip gcd and division.
// Reset: asynchronous active low, clears control state and empties the queue.
module rational_arith_unit_core import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  localparam int MW = 2 * OPERAND_WIDTH + 1;
  localparam int CW = $bits(rau_ctl_t);
  localparam int DW = CW + 2 * MW;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [MW-1:0] f_num, f_den;
  rau_ctl_t      f_ctl;
  logic [DW-1:0] b_data;

  rau_front #(.W(OPERAND_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(f_valid),
    .push_ready_i(f_ready),
    .num_mag_o   (f_num),
    .den_mag_o   (f_den),
    .ctl_o       (f_ctl)
  );

  rau_fifo #(.DW(DW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_ctl, f_num, f_den}),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (b_data)
  );

  rau_back #(.W(OPERAND_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(b_valid),
    .pop_ready_o(b_ready),
    .num_mag_i  (b_data[2*MW-1:MW]),
    .den_mag_i  (b_data[MW-1:0]),
    .ctl_i      (rau_ctl_t'(b_data[DW-1:2*MW])),
    .out_o      (out_o)
  );

endmodule

### rtl/rau_front.sv
module rau_front import rau_pkg::*; #(
  parameter int W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rau_in_if.sink            in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [2*W:0]      num_mag_o,
  output logic [2*W:0]      den_mag_o,
  output rau_ctl_t          ctl_o
);

  localparam int PW = 2 * W;

  front_state_e state_q, state_d;
  logic [1:0]          cnt_q;
  logic [1:0]          op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] p_q [4];

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] product;
  logic                 accept;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_i.valid) state_d = F_MUL;
      F_MUL:  if (cnt_q == 2'd3) state_d = F_PUSH;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready   = (state_q == F_IDLE);
    push_valid_o = (state_q == F_PUSH);
  end

  // one shared multiplier, one cross product per cycle
  always_comb begin
    case (cnt_q)
      2'd0:    begin mul_a = an_q; mul_b = bd_q; end
      2'd1:    begin mul_a = bn_q; mul_b = ad_q; end
      2'd2:    begin mul_a = an_q; mul_b = bn_q; end
      default: begin mul_a = ad_q; mul_b = bd_q; end
    endcase
    product = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= 2'd0;
      else if (state_q == F_MUL) cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i.operation;
      an_q <= in_i.a_numerator;
      ad_q <= in_i.a_denominator;
      bn_q <= in_i.b_numerator;
      bd_q <= in_i.b_denominator;
    end
    if (state_q == F_MUL) p_q[cnt_q] <= product;
  end

  // classify and form the unreduced result
  logic signed [PW:0] e0, e1, e2, e3, num_s, den_s;
  logic den_zero, flip, eq, gt;

  always_comb begin
    e0 = {p_q[0][PW-1], p_q[0]};
    e1 = {p_q[1][PW-1], p_q[1]};
    e2 = {p_q[2][PW-1], p_q[2]};
    e3 = {p_q[3][PW-1], p_q[3]};
    case (op_e'(op_q))
      OP_ADD:  begin num_s = e0 + e1; den_s = e3; end
      OP_SUB:  begin num_s = e0 - e1; den_s = e3; end
      OP_MUL:  begin num_s = e2;      den_s = e3; end
      OP_DIV:  begin num_s = e0;      den_s = e1; end
      default: begin num_s = e0;      den_s = e3; end
    endcase
    den_zero = (ad_q == '0) || (bd_q == '0);
    flip     = ad_q[W-1] ^ bd_q[W-1];
    eq       = (p_q[0] == p_q[1]);
    gt       = !eq && ((p_q[0] > p_q[1]) != flip);

    num_mag_o = num_s[PW] ? -num_s : num_s;
    den_mag_o = den_s[PW] ? -den_s : den_s;

    ctl_o.neg = num_s[PW] ^ den_s[PW];
    if (den_zero) begin
      ctl_o.status    = ST_DEN_ZERO;
      ctl_o.a_greater = 1'b0;
      ctl_o.a_equal   = 1'b0;
      ctl_o.a_less    = 1'b0;
    end else begin
      ctl_o.status    = (op_e'(op_q) == OP_DIV && bn_q == '0) ? ST_DIV_ZERO : ST_OK;
      ctl_o.a_greater = gt;
      ctl_o.a_equal   = eq;
      ctl_o.a_less    = !eq && !gt;
    end
  end

endmodule

### rtl/rau_fifo.sv
module rau_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/rau_back.sv
module rau_back import rau_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  logic [2*W:0] num_mag_i,
  input  logic [2*W:0] den_mag_i,
  input  rau_ctl_t     ctl_i,
  rau_out_if.source    out_o
);

  localparam int MW  = 2 * W + 1;
  localparam int KW  = $clog2(MW + 1);
  localparam int NEW = (MW > NUM_W) ? MW : NUM_W;
  localparam int DEW = (MW > DEN_W) ? MW : DEN_W;

  back_state_e state_q, state_d;
  logic [MW-1:0] x_q, y_q, nm_q, dm_q, rn_q, rd_q;
  logic [KW-1:0] k_q, cnt_q;
  rau_ctl_t      ctl_q;

  logic signed [NUM_W-1:0] res_num_q;
  logic [DEN_W-1:0]        res_den_q;

  logic          take, gcd_done, div_last;
  logic [MW:0]   rn_sh, rd_sh;
  logic [MW-1:0] rn_nxt, rd_nxt, qn_nxt, qd_nxt;
  logic [NEW-1:0] qn_ext;
  logic [DEW-1:0] qd_ext;

  assign take     = pop_valid_i && pop_ready_o;
  assign gcd_done = (x_q == '0);
  assign div_last = (cnt_q == KW'(MW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (pop_valid_i) state_d = (ctl_i.status == ST_OK) ? B_GCD : B_OUT;
      B_GCD:  if (gcd_done) state_d = B_DIV;
      B_DIV:  if (div_last) state_d = B_OUT;
      B_OUT:  if (out_o.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o              = (state_q == B_IDLE);
    out_o.valid              = (state_q == B_OUT);
    out_o.result_numerator   = res_num_q;
    out_o.result_denominator = res_den_q;
    out_o.status             = ctl_q.status;
    out_o.a_greater          = ctl_q.a_greater;
    out_o.a_equal            = ctl_q.a_equal;
    out_o.a_less             = ctl_q.a_less;
  end

  // restoring division step on both magnitudes by the odd part of the gcd
  always_comb begin
    rn_sh = {rn_q, nm_q[MW-1]};
    rd_sh = {rd_q, dm_q[MW-1]};
    if (rn_sh >= {1'b0, y_q}) begin
      rn_nxt = MW'(rn_sh - {1'b0, y_q});
      qn_nxt = {nm_q[MW-2:0], 1'b1};
    end else begin
      rn_nxt = rn_sh[MW-1:0];
      qn_nxt = {nm_q[MW-2:0], 1'b0};
    end
    if (rd_sh >= {1'b0, y_q}) begin
      rd_nxt = MW'(rd_sh - {1'b0, y_q});
      qd_nxt = {dm_q[MW-2:0], 1'b1};
    end else begin
      rd_nxt = rd_sh[MW-1:0];
      qd_nxt = {dm_q[MW-2:0], 1'b0};
    end
    qn_ext = NEW'(qn_nxt);
    qd_ext = DEW'(qd_nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (take) begin
          x_q       <= num_mag_i;
          y_q       <= den_mag_i;
          nm_q      <= num_mag_i;
          dm_q      <= den_mag_i;
          k_q       <= '0;
          ctl_q     <= ctl_i;
          res_num_q <= '0;
          res_den_q <= '0;
        end
      end
      B_GCD: begin
        if (gcd_done) begin
          // strip the common power of two, divide by the odd part next
          nm_q  <= nm_q >> k_q;
          dm_q  <= dm_q >> k_q;
          rn_q  <= '0;
          rd_q  <= '0;
          cnt_q <= '0;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      B_DIV: begin
        nm_q  <= qn_nxt;
        dm_q  <= qd_nxt;
        rn_q  <= rn_nxt;
        rd_q  <= rd_nxt;
        cnt_q <= cnt_q + KW'(1);
        if (div_last) begin
          res_num_q <= ctl_q.neg ? NUM_W'(-qn_ext) : NUM_W'(qn_ext);
          res_den_q <= DEN_W'(qd_ext);
        end
      end
      default: ;
    endcase
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |->
      out_o.result_numerator == '0 && out_o.result_denominator == '0)
    else $error("error result carries nonzero fraction");

  a_den_zero_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_DEN_ZERO |->
      !(out_o.a_greater || out_o.a_equal || out_o.a_less))
    else $error("comparison flags set with zero denominator");

  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_DEN_ZERO |->
      $onehot({out_o.a_greater, out_o.a_equal, out_o.a_less}))
    else $error("comparison flags not one-hot");

  a_gcd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_GCD |-> y_q != '0)
    else $error("gcd operand reached zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res_num_q))
    else $error("result dropped while stalled");

endmodule
